FILE: src/stv_pkg.sv
`default_nettype none

package stv_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W = 32;
	localparam int IDX_W = 3;
	localparam int NW = 2 * W + 2;
	localparam int DW = NW + FRAC_BITS;
	localparam int CW = 4 * W;
	localparam int QB = 64 - FRAC_BITS;
	localparam int VW = QB + 3;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

	typedef enum logic [IDX_W-1:0] {
		REG_SCALE   = 3'd0,
		REG_ROT_X   = 3'd1,
		REG_ROT_Y   = 3'd2,
		REG_ROT_Z   = 3'd3,
		REG_ROT_W   = 3'd4,
		REG_SHIFT_X = 3'd5,
		REG_SHIFT_Y = 3'd6,
		REG_SHIFT_Z = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [W-1:0] scale;
		logic signed [W-1:0] rot_x;
		logic signed [W-1:0] rot_y;
		logic signed [W-1:0] rot_z;
		logic signed [W-1:0] rot_w;
		logic signed [W-1:0] shift_x;
		logic signed [W-1:0] shift_y;
		logic signed [W-1:0] shift_z;
	} cfg_t;

	typedef struct packed {
		logic                mode;
		logic signed [W-1:0] in_x;
		logic signed [W-1:0] in_y;
		logic signed [W-1:0] in_z;
	} vec_t;

	typedef struct packed {
		logic [2:0]          neg;
		logic [2:0][CW-1:0]  mag;
		logic [DW-1:0]       d;
		logic                bad;
		logic                mode;
	} rot_t;

	typedef struct packed {
		logic [2:0]          neg;
		logic [2:0][QB:0]    quo;
		logic                bad;
		logic                mode;
	} div_t;

	typedef struct packed {
		logic signed [W-1:0] out_x;
		logic signed [W-1:0] out_y;
		logic signed [W-1:0] out_z;
		logic                saturated;
		logic                bad_rotation;
	} res_t;

endpackage

`default_nettype wire

FILE: src/stv_if.sv
`default_nettype none

interface stv_vec_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic signed [stv_pkg::W-1:0] in_x;
	logic signed [stv_pkg::W-1:0] in_y;
	logic signed [stv_pkg::W-1:0] in_z;
	modport source (output valid, output mode, output in_x, output in_y, output in_z,
		input ready);
	modport sink (input valid, input mode, input in_x, input in_y, input in_z,
		output ready);
endinterface

interface stv_res_if;
	logic                         valid;
	logic                         ready;
	logic signed [stv_pkg::W-1:0] out_x;
	logic signed [stv_pkg::W-1:0] out_y;
	logic signed [stv_pkg::W-1:0] out_z;
	logic                         saturated;
	logic                         bad_rotation;
	modport source (output valid, output out_x, output out_y, output out_z,
		output saturated, output bad_rotation, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z,
		input saturated, input bad_rotation, output ready);
endinterface

interface stv_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [stv_pkg::IDX_W-1:0]        index;
	logic [stv_pkg::W-1:0]            data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/stv_rot.sv
`default_nettype none

module stv_rot (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire stv_pkg::cfg_t  cfg,
	input  wire logic           up_valid,
	output logic                up_ready,
	input  wire stv_pkg::vec_t  up_data,
	output logic                dn_valid,
	input  wire logic           dn_ready,
	output stv_pkg::rot_t       dn_data
);

	localparam int W = stv_pkg::W;
	localparam int CW = stv_pkg::CW;
	localparam int NW = stv_pkg::NW;
	localparam int NS = 8;
	localparam int NK = 12;

	// q * (p,0): quaternion index (x,y,z,w), vector index, subtract
	localparam int P1_Q [NK] = '{0, 1, 2, 3, 1, 2, 3, 0, 2, 3, 0, 1};
	localparam int P1_P [NK] = '{0, 1, 2, 0, 2, 1, 1, 2, 0, 2, 1, 0};
	localparam bit P1_NEG [NK] = '{1, 1, 1, 0, 0, 1, 0, 1, 0, 0, 0, 1};
	// (w1,x1,y1,z1) * conj(q), product 4*c+r for component c
	localparam int P2_Q [NK] = '{0, 3, 2, 1, 1, 2, 3, 0, 2, 1, 0, 3};
	localparam bit P2_NEG [NK] = '{1, 0, 1, 0, 1, 0, 0, 1, 1, 1, 0, 0};

	logic signed [W-1:0] qv [4];
	logic signed [W-1:0] vin [3];
	logic [NS:1] vld_s;
	logic [NS:1] adv;

	logic signed [2*W-1:0] p_s1 [3];
	logic signed [2*W-1:0] sq_s1 [4];
	logic                  mode_s1;

	logic signed [2*W:0]   lo_s2 [NK];
	logic signed [2*W-1:0] hi_s2 [NK];
	logic [NW-1:0]         n_s2;
	logic                  mode_s2;

	logic [3*W-1:0]        pr_s3 [NK];
	logic [NW-1:0]         n_s3;
	logic                  mode_s3;

	logic [3*W-1:0]        f_d [4];
	logic [3*W-1:0]        f_s4 [4];
	logic [NW-1:0]         n_s4;
	logic                  mode_s4;

	logic signed [2*W:0]   pa_s5 [NK];
	logic signed [2*W:0]   pb_s5 [NK];
	logic signed [2*W-1:0] pc_s5 [NK];
	logic [NW-1:0]         n_s5;
	logic                  mode_s5;

	logic [CW-1:0]         pr2_s6 [NK];
	logic [NW-1:0]         n_s6;
	logic                  mode_s6;

	logic [CW-1:0]         comp_d [3];
	logic [CW-1:0]         comp_s7 [3];
	logic [NW-1:0]         n_s7;
	logic                  mode_s7;

	stv_pkg::rot_t         rot_s8;

	assign qv[0] = cfg.rot_x;
	assign qv[1] = cfg.rot_y;
	assign qv[2] = cfg.rot_z;
	assign qv[3] = cfg.rot_w;
	assign vin[0] = up_data.in_x;
	assign vin[1] = up_data.in_y;
	assign vin[2] = up_data.in_z;

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		adv[NS] = !vld_s[NS] || dn_ready;
		for (int i = NS - 1; i >= 1; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign up_ready = adv[1];
	assign dn_valid = vld_s[NS];
	assign dn_data = rot_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= up_valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// scaled vector and quaternion squares
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int j = 0; j < 3; j++) begin
				p_s1[j] <= vin[j] * cfg.scale;
			end
			for (int k = 0; k < 4; k++) begin
				sq_s1[k] <= qv[k] * qv[k];
			end
			mode_s1 <= up_data.mode;
		end
	end

	// first product, split in two 32-bit halves of p
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int k = 0; k < NK; k++) begin
				lo_s2[k] <= qv[P1_Q[k]] * $signed({1'b0, p_s1[P1_P[k]][W-1:0]});
				hi_s2[k] <= qv[P1_Q[k]] * $signed(p_s1[P1_P[k]][2*W-1:W]);
			end
			n_s2 <= {2'b00, sq_s1[0]} + {2'b00, sq_s1[1]} + {2'b00, sq_s1[2]}
				+ {2'b00, sq_s1[3]};
			mode_s2 <= mode_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int k = 0; k < NK; k++) begin
				pr_s3[k] <= {hi_s2[k], {W{1'b0}}} + {{(W-1){lo_s2[k][2*W]}}, lo_s2[k]};
			end
			n_s3 <= n_s2;
			mode_s3 <= mode_s2;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			f_d[r] = '0;
			for (int j = 0; j < 3; j++) begin
				if (P1_NEG[3*r+j]) begin
					f_d[r] = f_d[r] - pr_s3[3*r+j];
				end else begin
					f_d[r] = f_d[r] + pr_s3[3*r+j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			f_s4 <= f_d;
			n_s4 <= n_s3;
			mode_s4 <= mode_s3;
		end
	end

	// second product, three 32-bit slices of the intermediate term
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int m = 0; m < NK; m++) begin
				pa_s5[m] <= qv[P2_Q[m]] * $signed({1'b0, f_s4[m % 4][W-1:0]});
				pb_s5[m] <= qv[P2_Q[m]] * $signed({1'b0, f_s4[m % 4][2*W-1:W]});
				pc_s5[m] <= qv[P2_Q[m]] * $signed(f_s4[m % 4][3*W-1:2*W]);
			end
			n_s5 <= n_s4;
			mode_s5 <= mode_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int m = 0; m < NK; m++) begin
				pr2_s6[m] <= {pc_s5[m], {(2*W){1'b0}}}
					+ {{(W-1){pb_s5[m][2*W]}}, pb_s5[m], {W{1'b0}}}
					+ {{(2*W-1){pa_s5[m][2*W]}}, pa_s5[m]};
			end
			n_s6 <= n_s5;
			mode_s6 <= mode_s5;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			comp_d[c] = '0;
			for (int r = 0; r < 4; r++) begin
				if (P2_NEG[4*c+r]) begin
					comp_d[c] = comp_d[c] - pr2_s6[4*c+r];
				end else begin
					comp_d[c] = comp_d[c] + pr2_s6[4*c+r];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			comp_s7 <= comp_d;
			n_s7 <= n_s6;
			mode_s7 <= mode_s6;
		end
	end

	// sign and magnitude for the divider, divisor is |q|^2 scaled up
	always_ff @(posedge clk) begin
		if (adv[8]) begin
			for (int j = 0; j < 3; j++) begin
				rot_s8.neg[j] <= comp_s7[j][CW-1];
				rot_s8.mag[j] <= comp_s7[j][CW-1] ? (~comp_s7[j] + CW'(1)) : comp_s7[j];
			end
			rot_s8.d <= {n_s7, {stv_pkg::FRAC_BITS{1'b0}}};
			rot_s8.bad <= (n_s7 == '0);
			rot_s8.mode <= mode_s7;
		end
	end

endmodule

`default_nettype wire

FILE: src/stv_div.sv
`default_nettype none

module stv_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           up_valid,
	output logic                up_ready,
	input  wire stv_pkg::rot_t  up_data,
	output logic                dn_valid,
	input  wire logic           dn_ready,
	output stv_pkg::div_t       dn_data
);

	localparam int QB = stv_pkg::QB;
	localparam int CW = stv_pkg::CW;
	localparam int DW = stv_pkg::DW;

	// stages 0..QB-1 each settle one quotient bit, stage QB rounds
	logic [QB:0] vld_s;
	logic [QB:0] adv;

	logic [2:0][CW-1:0] rem_s [QB];
	logic [2:0][QB-1:0] quo_s [QB];
	logic [DW-1:0]      d_s [QB];
	logic [2:0]         neg_s [QB+1];
	logic               bad_s [QB+1];
	logic               mode_s [QB+1];
	logic [2:0][QB:0]   qr_s;

	logic [2:0][CW-1:0] rem_nx [QB];
	logic [2:0][QB-1:0] quo_nx [QB];
	logic [2:0][QB:0]   qr_nx;

	always_comb begin
		adv[QB] = !vld_s[QB] || dn_ready;
		for (int i = QB - 1; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign up_ready = adv[0];
	assign dn_valid = vld_s[QB];

	always_comb begin
		logic [2:0][CW-1:0] ri;
		logic [2:0][QB-1:0] qi;
		logic [DW-1:0]      di;
		logic [CW+1:0]      dsh;
		logic [CW+1:0]      diff;
		for (int i = 0; i < QB; i++) begin
			if (i == 0) begin
				ri = up_data.mag;
				qi = '0;
				di = up_data.d;
			end else begin
				ri = rem_s[i-1];
				qi = quo_s[i-1];
				di = d_s[i-1];
			end
			dsh = {{(CW+2-DW){1'b0}}, di} << (QB - 1 - i);
			for (int l = 0; l < 3; l++) begin
				diff = {2'b00, ri[l]} - dsh;
				rem_nx[i][l] = diff[CW+1] ? ri[l] : diff[CW-1:0];
				quo_nx[i][l] = qi[l];
				quo_nx[i][l][QB-1-i] = !diff[CW+1];
			end
		end
	end

	// round half away from zero on the magnitude
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qr_nx[l] = {1'b0, quo_s[QB-1][l]}
				+ (QB+1)'({rem_s[QB-1][l], 1'b0} >= {{(CW+1-DW){1'b0}}, d_s[QB-1]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= up_valid;
			end
			for (int i = 1; i <= QB; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QB; i++) begin
			if (adv[i]) begin
				rem_s[i] <= rem_nx[i];
				quo_s[i] <= quo_nx[i];
				if (i == 0) begin
					d_s[i] <= up_data.d;
				end else begin
					d_s[i] <= d_s[i-1];
				end
			end
		end
		for (int i = 0; i <= QB; i++) begin
			if (adv[i]) begin
				if (i == 0) begin
					neg_s[i] <= up_data.neg;
					bad_s[i] <= up_data.bad;
					mode_s[i] <= up_data.mode;
				end else begin
					neg_s[i] <= neg_s[i-1];
					bad_s[i] <= bad_s[i-1];
					mode_s[i] <= mode_s[i-1];
				end
			end
		end
		if (adv[QB]) begin
			qr_s <= qr_nx;
		end
	end

	always_comb begin
		dn_data.neg = neg_s[QB];
		dn_data.quo = qr_s;
		dn_data.bad = bad_s[QB];
		dn_data.mode = mode_s[QB];
	end

endmodule

`default_nettype wire

FILE: src/similarity_transform_vector.sv
// Similarity transform of a 3D vector in signed Q16.16: uniform scale, quaternion
// rotation q.v.conj(q)/|q|^2, then translation for points (mode 0) only.
// Channels: cfg writes one of eight registers (scale, rot_x/y/z/w, shift_x/y/z)
// by index and is always ready; write it only while no vector is in flight.
// vec carries mode and in_x/in_y/in_z; res returns out_x/out_y/out_z with
// saturated (a component was clamped to 32 bits) and bad_rotation (zero
// quaternion, coordinates then zero).
// Throughput: one vector per cycle while res is ready. From vec transfer to
// res valid a vector passes eight stages of multiply and add, one stage per
// quotient bit of the divide by |q|^2 that gives the Q16.16 result plus a
// rounding stage, and the output register holding translation and clamp.
// Reset loads scale and rot_w with 1.0, the rest with 0, and empties the pipe.
// When res stalls, stages keep filling up bubbles; vec.ready drops only once
// every stage and the output register hold a vector.
`default_nettype none

module similarity_transform_vector (
	input  wire logic clk,
	input  wire logic arst_n,
	stv_cfg_if.sink   cfg,
	stv_vec_if.sink   vec,
	stv_res_if.source res
);

	localparam int W = stv_pkg::W;
	localparam int QB = stv_pkg::QB;
	localparam int VW = stv_pkg::VW;

	stv_pkg::cfg_t cfg_q;
	stv_pkg::vec_t vec_d;
	stv_pkg::rot_t rot_data;
	stv_pkg::div_t div_data;
	stv_pkg::res_t res_d;
	stv_pkg::res_t res_s;
	logic          rot_valid;
	logic          rot_ready;
	logic          div_valid;
	logic          div_ready;
	logic          res_v_s;
	logic          res_ld;
	logic signed [W-1:0] sh [3];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale <= stv_pkg::ONE;
			cfg_q.rot_x <= '0;
			cfg_q.rot_y <= '0;
			cfg_q.rot_z <= '0;
			cfg_q.rot_w <= stv_pkg::ONE;
			cfg_q.shift_x <= '0;
			cfg_q.shift_y <= '0;
			cfg_q.shift_z <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				stv_pkg::REG_SCALE:   cfg_q.scale <= cfg.data;
				stv_pkg::REG_ROT_X:   cfg_q.rot_x <= cfg.data;
				stv_pkg::REG_ROT_Y:   cfg_q.rot_y <= cfg.data;
				stv_pkg::REG_ROT_Z:   cfg_q.rot_z <= cfg.data;
				stv_pkg::REG_ROT_W:   cfg_q.rot_w <= cfg.data;
				stv_pkg::REG_SHIFT_X: cfg_q.shift_x <= cfg.data;
				stv_pkg::REG_SHIFT_Y: cfg_q.shift_y <= cfg.data;
				stv_pkg::REG_SHIFT_Z: cfg_q.shift_z <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		vec_d.mode = vec.mode;
		vec_d.in_x = vec.in_x;
		vec_d.in_y = vec.in_y;
		vec_d.in_z = vec.in_z;
	end

	stv_rot u_rot (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (vec.valid),
		.up_ready (vec.ready),
		.up_data  (vec_d),
		.dn_valid (rot_valid),
		.dn_ready (rot_ready),
		.dn_data  (rot_data)
	);

	stv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (rot_valid),
		.up_ready (rot_ready),
		.up_data  (rot_data),
		.dn_valid (div_valid),
		.dn_ready (div_ready),
		.dn_data  (div_data)
	);

	assign sh[0] = cfg_q.shift_x;
	assign sh[1] = cfg_q.shift_y;
	assign sh[2] = cfg_q.shift_z;

	// apply sign, translate points, clamp to 32 bits; a zero quaternion gives zeros
	always_comb begin
		logic signed [VW-1:0] val;
		logic [2:0][W-1:0]    ov;
		logic                 sat;
		logic                 ovf;
		sat = 1'b0;
		for (int j = 0; j < 3; j++) begin
			val = {{(VW-QB-1){1'b0}}, div_data.quo[j]};
			if (div_data.neg[j]) begin
				val = -val;
			end
			if (!div_data.mode) begin
				val = val + {{(VW-W){sh[j][W-1]}}, sh[j]};
			end
			ovf = !((&val[VW-1:W-1]) || !(|val[VW-1:W-1]));
			if (ovf) begin
				sat = 1'b1;
				ov[j] = val[VW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else begin
				ov[j] = val[W-1:0];
			end
		end
		if (div_data.bad) begin
			res_d.out_x = '0;
			res_d.out_y = '0;
			res_d.out_z = '0;
			res_d.saturated = 1'b0;
			res_d.bad_rotation = 1'b1;
		end else begin
			res_d.out_x = ov[0];
			res_d.out_y = ov[1];
			res_d.out_z = ov[2];
			res_d.saturated = sat;
			res_d.bad_rotation = 1'b0;
		end
	end

	assign res_ld = !res_v_s || res.ready;
	assign div_ready = res_ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s <= 1'b0;
		end else if (res_ld) begin
			res_v_s <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_s <= res_d;
		end
	end

	assign res.valid = res_v_s;
	assign res.out_x = res_s.out_x;
	assign res.out_y = res_s.out_y;
	assign res.out_z = res_s.out_z;
	assign res.saturated = res_s.saturated;
	assign res.bad_rotation = res_s.bad_rotation;

	// input backs up only when every stage down to the output is full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!vec.ready |-> res.valid)
		else $error("input stalled with an empty output");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.bad_rotation |-> res.out_x == '0 && res.out_y == '0
			&& res.out_z == '0 && !res.saturated)
		else $error("zero quaternion result not cleared");

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && !div_ready |=> div_valid && $stable(div_data))
		else $error("divider output changed under stall");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench;
	import stv_pkg::*;

	typedef enum logic [1:0] {K_VEC, K_CFG, K_DRAIN} kind_t;

	typedef struct {
		kind_t    kind;
		vec_t     v;
		reg_idx_t idx;
		logic [W-1:0] data;
	} job_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stv_cfg_if cfg_ch();
	stv_vec_if vec_ch();
	stv_res_if res_ch();

	similarity_transform_vector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch.sink),
		.vec    (vec_ch.sink),
		.res    (res_ch.source)
	);

	always #1 clk = ~clk;

	job_t pending[$];
	res_t expected_res[$];
	cfg_t model_cfg;
	cfg_t pick;
	logic vec_busy = 1'b0, cfg_busy = 1'b0;
	logic vec_took = 1'b0, cfg_took = 1'b0;
	int drain_cnt = 0;
	int errors = 0;
	int vec_sent = 0, res_seen = 0, sat_seen = 0, bad_seen = 0, cfg_writes = 0;
	logic calm;

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SCALE;
		cfg_ch.data = '0;
		vec_ch.valid = 1'b0;
		vec_ch.mode = 1'b0;
		vec_ch.in_x = '0;
		vec_ch.in_y = '0;
		vec_ch.in_z = '0;
		res_ch.ready = 1'b0;
	end

	assign calm = (vec_sent >= 500) && (vec_sent < 700);

	function automatic res_t transform_vec(vec_t v, cfg_t c);
		logic signed [191:0] qx, qy, qz, qw, n, px, py, pz, w1, x1, y1, z1, d, mag, quo, rm;
		logic signed [191:0] comp[3];
		logic signed [63:0] val;
		logic signed [63:0] sh[3];
		logic [W-1:0] o[3];
		logic sat;
		res_t r;
		qx = c.rot_x;
		qy = c.rot_y;
		qz = c.rot_z;
		qw = c.rot_w;
		n = qw * qw + qx * qx + qy * qy + qz * qz;
		r = '0;
		if (n == 0) begin
			r.bad_rotation = 1'b1;
			return r;
		end
		px = c.scale * v.in_x;
		py = c.scale * v.in_y;
		pz = c.scale * v.in_z;
		w1 = -(qx * px + qy * py + qz * pz);
		x1 = qw * px + qy * pz - qz * py;
		y1 = qw * py - qx * pz + qz * px;
		z1 = qw * pz + qx * py - qy * px;
		comp[0] = -(w1 * qx) + x1 * qw - y1 * qz + z1 * qy;
		comp[1] = -(w1 * qy) + x1 * qz + y1 * qw - z1 * qx;
		comp[2] = -(w1 * qz) - x1 * qy + y1 * qx + z1 * qw;
		d = n <<< FRAC_BITS;
		sh[0] = c.shift_x;
		sh[1] = c.shift_y;
		sh[2] = c.shift_z;
		sat = 1'b0;
		for (int j = 0; j < 3; j++) begin
			mag = (comp[j] < 0) ? -comp[j] : comp[j];
			quo = mag / d;
			rm = mag - quo * d;
			// round half away from zero on the magnitude
			if (rm * 2 >= d)
				quo = quo + 1;
			val = {2'b00, quo[61:0]};
			if (comp[j] < 0)
				val = -val;
			if (!v.mode)
				val = val + sh[j];
			if (val > 64'sd2147483647) begin
				val = 64'sd2147483647;
				sat = 1'b1;
			end else if (val < -64'sd2147483648) begin
				val = -64'sd2147483648;
				sat = 1'b1;
			end
			o[j] = val[W-1:0];
		end
		r.out_x = o[0];
		r.out_y = o[1];
		r.out_z = o[2];
		r.saturated = sat;
		return r;
	endfunction

	function automatic logic [W-1:0] rnd_word(int lo_shift);
		logic signed [W-1:0] x;
		x = $urandom;
		return x >>> $urandom_range(lo_shift, 31);
	endfunction

	task automatic add_vec(logic m, logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z);
		job_t j;
		j.kind = K_VEC;
		j.v.mode = m;
		j.v.in_x = x;
		j.v.in_y = y;
		j.v.in_z = z;
		j.idx = REG_SCALE;
		j.data = '0;
		pending.push_back(j);
	endtask

	task automatic add_drain();
		job_t j;
		j.kind = K_DRAIN;
		j.v = '0;
		j.idx = REG_SCALE;
		j.data = '0;
		pending.push_back(j);
	endtask

	task automatic add_reg(reg_idx_t i, logic [W-1:0] val);
		job_t j;
		j.kind = K_CFG;
		j.v = '0;
		j.idx = i;
		j.data = val;
		pending.push_back(j);
	endtask

	// register writes only after the pipe has emptied
	task automatic add_setting(cfg_t c);
		add_drain();
		add_reg(REG_SCALE, c.scale);
		add_reg(REG_ROT_X, c.rot_x);
		add_reg(REG_ROT_Y, c.rot_y);
		add_reg(REG_ROT_Z, c.rot_z);
		add_reg(REG_ROT_W, c.rot_w);
		add_reg(REG_SHIFT_X, c.shift_x);
		add_reg(REG_SHIFT_Y, c.shift_y);
		add_reg(REG_SHIFT_Z, c.shift_z);
	endtask

	task automatic add_random_vec();
		if ($urandom_range(0, 3) == 0)
			add_vec($urandom_range(0, 1), $urandom, $urandom, $urandom);
		else
			add_vec($urandom_range(0, 1), rnd_word(4), rnd_word(4), rnd_word(4));
	endtask

	initial begin
		// default setting after reset: identity
		add_vec(1'b0, 32'sh7fffffff, 32'sh80000000, '0);
		add_vec(1'b1, 32'sh80000000, 32'sh7fffffff, 32'shffffffff);
		add_vec(1'b0, ONE, -ONE, 32'sd1);
		add_vec(1'b1, '0, '0, '0);
		pick = '{scale: 32'sh7fffffff, rot_x: 32'sh7fffffff, rot_y: 32'sh80000000,
			rot_z: 32'sh7fffffff, rot_w: 32'sh80000000, shift_x: 32'sh7fffffff,
			shift_y: 32'sh80000000, shift_z: 32'sh7fffffff};
		add_setting(pick);
		add_vec(1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
		add_vec(1'b1, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
		add_vec(1'b0, 32'sd1, -32'sd1, 32'sd0);
		add_vec(1'b1, 32'sd3, 32'sd5, -32'sd7);
		// zero quaternion
		pick = '{scale: ONE, rot_x: 0, rot_y: 0, rot_z: 0, rot_w: 0,
			shift_x: ONE, shift_y: -ONE, shift_z: 32'sd5};
		add_setting(pick);
		add_vec(1'b0, ONE, ONE, ONE);
		add_vec(1'b1, 32'sh7fffffff, 32'sh80000000, 32'sd1);
		// half turn about z, most negative scale
		pick = '{scale: 32'sh80000000, rot_x: 0, rot_y: 0, rot_z: 32'sd1, rot_w: 0,
			shift_x: 32'sh80000000, shift_y: 32'sh7fffffff, shift_z: 0};
		add_setting(pick);
		add_vec(1'b0, 32'sd1, 32'sd2, 32'sd3);
		add_vec(1'b1, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
		pick = '{scale: 32'sd32768, rot_x: ONE, rot_y: ONE, rot_z: ONE, rot_w: ONE,
			shift_x: 32'sd3, shift_y: 0, shift_z: -32'sd3};
		add_setting(pick);
		add_vec(1'b0, 32'sd1, 32'sd1, 32'sd1);
		add_vec(1'b1, 32'sd3, -32'sd3, 32'sd1);
		add_vec(1'b0, 32'sh7fffffff, 32'sd0, 32'sh80000000);
		for (int ph = 0; ph < 13; ph++) begin
			pick.scale = ($urandom_range(0, 3) == 0) ? $urandom : rnd_word(8);
			pick.rot_x = ($urandom_range(0, 4) == 0) ? $urandom : rnd_word(6);
			pick.rot_y = ($urandom_range(0, 4) == 0) ? $urandom : rnd_word(6);
			pick.rot_z = ($urandom_range(0, 4) == 0) ? $urandom : rnd_word(6);
			pick.rot_w = ($urandom_range(0, 4) == 0) ? $urandom : rnd_word(6);
			pick.shift_x = $urandom;
			pick.shift_y = rnd_word(0);
			pick.shift_z = rnd_word(0);
			if (ph == 5) begin
				pick.rot_x = 0;
				pick.rot_y = 0;
				pick.rot_z = 0;
				pick.rot_w = 0;
			end
			if (ph == 8)
				pick.scale = 32'sh80000000;
			add_setting(pick);
			for (int k = 0; k < 100; k++)
				add_random_vec();
			// hold off until the pipe is empty; the next phase then writes a new setting
			if (ph == 3)
				add_drain();
		end
	end

	// reset and acceptance tracking
	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		vec_took <= vec_ch.valid && vec_ch.ready;
		cfg_took <= cfg_ch.valid && cfg_ch.ready;
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			cfg_writes <= cfg_writes + 1;
			case (reg_idx_t'(cfg_ch.index))
				REG_SCALE:   model_cfg.scale <= cfg_ch.data;
				REG_ROT_X:   model_cfg.rot_x <= cfg_ch.data;
				REG_ROT_Y:   model_cfg.rot_y <= cfg_ch.data;
				REG_ROT_Z:   model_cfg.rot_z <= cfg_ch.data;
				REG_ROT_W:   model_cfg.rot_w <= cfg_ch.data;
				REG_SHIFT_X: model_cfg.shift_x <= cfg_ch.data;
				REG_SHIFT_Y: model_cfg.shift_y <= cfg_ch.data;
				REG_SHIFT_Z: model_cfg.shift_z <= cfg_ch.data;
				default: ;
			endcase
		end
		if (arst_n && vec_ch.valid && vec_ch.ready) begin
			expected_res.push_back(transform_vec(
				'{mode: vec_ch.mode, in_x: vec_ch.in_x, in_y: vec_ch.in_y, in_z: vec_ch.in_z},
				model_cfg));
			vec_sent <= vec_sent + 1;
		end
	end

	initial model_cfg = '{scale: ONE, rot_x: 0, rot_y: 0, rot_z: 0, rot_w: ONE,
		shift_x: 0, shift_y: 0, shift_z: 0};

	// driver
	always @(negedge clk) begin
		job_t j;
		logic nv, nc;
		if (arst_n) begin
			nv = vec_busy && !vec_took;
			nc = cfg_busy && !cfg_took;
			if (!nv && !nc && pending.size() != 0) begin
				j = pending[0];
				case (j.kind)
					K_DRAIN: begin
						if (expected_res.size() == 0 && !vec_ch.valid) begin
							if (drain_cnt >= 64) begin
								drain_cnt = 0;
								void'(pending.pop_front());
							end else
								drain_cnt = drain_cnt + 1;
						end
					end
					K_CFG: begin
						void'(pending.pop_front());
						cfg_ch.index <= j.idx;
						cfg_ch.data <= j.data;
						nc = 1'b1;
					end
					default: begin
						if (calm || $urandom_range(0, 99) >= 19) begin
							void'(pending.pop_front());
							vec_ch.mode <= j.v.mode;
							vec_ch.in_x <= j.v.in_x;
							vec_ch.in_y <= j.v.in_y;
							vec_ch.in_z <= j.v.in_z;
							nv = 1'b1;
						end
					end
				endcase
			end
			vec_busy = nv;
			cfg_busy = nc;
			vec_ch.valid <= nv;
			cfg_ch.valid <= nc;
			res_ch.ready <= calm || ($urandom_range(0, 99) >= 19);
		end
	end

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			res_seen <= res_seen + 1;
			if (res_ch.saturated)
				sat_seen <= sat_seen + 1;
			if (res_ch.bad_rotation)
				bad_seen <= bad_seen + 1;
			if (expected_res.size() == 0) begin
				$display("%0t: unexpected result %h %h %h sat %b bad %b", $time,
					res_ch.out_x, res_ch.out_y, res_ch.out_z,
					res_ch.saturated, res_ch.bad_rotation);
				errors <= errors + 1;
			end else begin
				want = expected_res.pop_front();
				if (res_ch.out_x !== want.out_x || res_ch.out_y !== want.out_y ||
						res_ch.out_z !== want.out_z || res_ch.saturated !== want.saturated ||
						res_ch.bad_rotation !== want.bad_rotation) begin
					$display("%0t: mismatch expected %h %h %h sat %b bad %b", $time,
						want.out_x, want.out_y, want.out_z, want.saturated,
						want.bad_rotation);
					$display("%0t:          actual   %h %h %h sat %b bad %b", $time,
						res_ch.out_x, res_ch.out_y, res_ch.out_z,
						res_ch.saturated, res_ch.bad_rotation);
					errors <= errors + 1;
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		repeat (2) @(posedge clk);
		wait (pending.size() == 0 && !vec_ch.valid && !cfg_ch.valid);
		wait (expected_res.size() == 0);
		repeat (80) @(posedge clk);
		if (expected_res.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_res.size());
			errors = errors + 1;
		end
		$display("vectors sent %0d, results checked %0d, register writes %0d",
			vec_sent, res_seen, cfg_writes);
		$display("saturated results %0d, zero-quaternion results %0d", sat_seen, bad_seen);
		if (errors == 0)
			$display("[similarity_transform_vector] OK");
		else
			$display("[similarity_transform_vector] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[similarity_transform_vector] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
